[rtl/core/tpi_pkg.sv]
// Shared types and cofactor index tables for the three-plane intersection core.
package tpi_pkg;

  typedef struct packed {
    logic valid;
    logic found;
  } tpi_ctl_t;

  typedef int unsigned idx_tab_t [9];

  // cofactor k = m[CF_A[k]] * m[CF_B[k]] - m[CF_C[k]] * m[CF_D[k]]
  localparam idx_tab_t CF_A = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam idx_tab_t CF_B = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam idx_tab_t CF_C = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam idx_tab_t CF_D = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

[rtl/core/tpi_front.sv]
// Front pipeline: cofactors, determinant, numerators, magnitudes and overflow test.
module tpi_front #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int NW          = 3 * VALUE_WIDTH + 4 + FRAC_BITS,
  parameter int SW          = 3 * VALUE_WIDTH + 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic signed [VALUE_WIDTH-1:0]       plane1_nx,
  input  logic signed [VALUE_WIDTH-1:0]       plane1_ny,
  input  logic signed [VALUE_WIDTH-1:0]       plane1_nz,
  input  logic signed [VALUE_WIDTH-1:0]       plane1_d,
  input  logic signed [VALUE_WIDTH-1:0]       plane2_nx,
  input  logic signed [VALUE_WIDTH-1:0]       plane2_ny,
  input  logic signed [VALUE_WIDTH-1:0]       plane2_nz,
  input  logic signed [VALUE_WIDTH-1:0]       plane2_d,
  input  logic signed [VALUE_WIDTH-1:0]       plane3_nx,
  input  logic signed [VALUE_WIDTH-1:0]       plane3_ny,
  input  logic signed [VALUE_WIDTH-1:0]       plane3_nz,
  input  logic signed [VALUE_WIDTH-1:0]       plane3_d,
  output tpi_pkg::tpi_ctl_t                   ctl,
  output logic [2:0][NW-1:0]                  num_mag,
  output logic [SW-1:0]                       den_mag,
  output logic [2:0]                          neg,
  output logic [2:0]                          ovf
);
  import tpi_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int CWD = 2 * W + 1;
  localparam int XW  = W + 1;
  localparam int PPW = 2 * W + 2;

  logic [5:0] vld;

  // stage A: operands
  logic signed [W-1:0]   am  [9];
  logic signed [XW-1:0]  amd [3];
  // stage B: products
  logic signed [2*W-1:0] bp0 [9];
  logic signed [2*W-1:0] bp1 [9];
  logic signed [W-1:0]   bm  [3];
  logic signed [XW-1:0]  bmd [3];
  // stage C: cofactors
  logic signed [CWD-1:0] cc  [9];
  logic signed [W-1:0]   cm  [3];
  logic signed [XW-1:0]  cmd [3];
  // stage D: partial products
  logic signed [PPW-1:0] dlo [12];
  logic signed [PPW-1:0] dhi [12];
  // stage E: full products
  logic signed [SW-1:0]  ef  [12];
  // stage F: sums
  logic signed [SW-1:0]  fdet;
  logic signed [SW-1:0]  fnum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    am[0]  <= plane1_nx;
    am[1]  <= plane1_ny;
    am[2]  <= plane1_nz;
    am[3]  <= plane2_nx;
    am[4]  <= plane2_ny;
    am[5]  <= plane2_nz;
    am[6]  <= plane3_nx;
    am[7]  <= plane3_ny;
    am[8]  <= plane3_nz;
    amd[0] <= XW'(0) - XW'(plane1_d);
    amd[1] <= XW'(0) - XW'(plane2_d);
    amd[2] <= XW'(0) - XW'(plane3_d);
  end

  for (genvar k = 0; k < 9; k++) begin : g_cof
    always_ff @(posedge clk) begin
      bp0[k] <= am[CF_A[k]] * am[CF_B[k]];
      bp1[k] <= am[CF_C[k]] * am[CF_D[k]];
      cc[k]  <= CWD'(bp0[k]) - CWD'(bp1[k]);
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_pass
    always_ff @(posedge clk) begin
      bm[j]  <= am[j];
      bmd[j] <= amd[j];
      cm[j]  <= bm[j];
      cmd[j] <= bmd[j];
    end
  end

  for (genvar t = 0; t < 12; t++) begin : g_prod
    localparam int CI = (t < 3) ? 3 * t : t - 3;
    logic signed [XW-1:0] x;
    if (t < 3) begin : g_det
      assign x = XW'(cm[t]);
    end else begin : g_num
      assign x = cmd[(t - 3) % 3];
    end
    always_ff @(posedge clk) begin
      dlo[t] <= x * $signed({1'b0, cc[CI][W-1:0]});
      dhi[t] <= x * $signed(cc[CI][CWD-1:W]);
      ef[t]  <= (SW'(dhi[t]) <<< W) + SW'(dlo[t]);
    end
  end

  always_ff @(posedge clk) begin
    fdet <= ef[0] + ef[1] + ef[2];
    for (int k = 0; k < 3; k++) begin
      fnum[k] <= ef[3 + 3 * k] + ef[4 + 3 * k] + ef[5 + 3 * k];
    end
  end

  // stage G: magnitudes, signs, quotient overflow
  logic [SW-1:0] dmag;
  logic [SW-1:0] nmag [3];
  logic [NW-1:0] nsh  [3];

  always_comb begin
    dmag = fdet[SW-1] ? SW'(-fdet) : SW'(fdet);
    for (int k = 0; k < 3; k++) begin
      nmag[k] = fnum[k][SW-1] ? SW'(-fnum[k]) : SW'(fnum[k]);
      nsh[k]  = NW'(nmag[k]) << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= vld[5];
    end
    ctl.found <= |fdet;
    den_mag   <= dmag;
    for (int k = 0; k < 3; k++) begin
      num_mag[k] <= nsh[k];
      neg[k]     <= fnum[k][SW-1] ^ fdet[SW-1];
      ovf[k]     <= (nsh[k] >> W) >= NW'(dmag);
    end
  end

endmodule

[rtl/core/tpi_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with signed saturation.
module tpi_div #(
  parameter int VALUE_WIDTH = 32,
  parameter int NW          = 116,
  parameter int DW          = 100
) (
  input  logic                          clk,
  input  logic [NW-1:0]                 num,
  input  logic [DW-1:0]                 den,
  input  logic                          neg_in,
  input  logic                          ovf_in,
  output logic signed [VALUE_WIDTH-1:0] coord,
  output logic                          sat
);
  localparam int W  = VALUE_WIDTH;
  localparam int RW = NW + W;

  logic [RW-1:0] rr [W];
  logic [W-1:0]  qq [W];
  logic [DW-1:0] dd [W];
  logic          nn [W];
  logic          oo [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int BI = W - 1 - s;
    logic [RW-1:0] r_prev, sh;
    logic [W-1:0]  q_prev, q_next;
    logic [DW-1:0] d_prev;
    logic          n_prev, o_prev, ge;
    if (s == 0) begin : g_first
      assign r_prev = RW'(num);
      assign q_prev = '0;
      assign d_prev = den;
      assign n_prev = neg_in;
      assign o_prev = ovf_in;
    end else begin : g_rest
      assign r_prev = rr[s-1];
      assign q_prev = qq[s-1];
      assign d_prev = dd[s-1];
      assign n_prev = nn[s-1];
      assign o_prev = oo[s-1];
    end
    always_comb begin
      sh         = RW'(d_prev) << BI;
      ge         = r_prev >= sh;
      q_next     = q_prev;
      q_next[BI] = ge;
    end
    always_ff @(posedge clk) begin
      rr[s] <= ge ? r_prev - sh : r_prev;
      qq[s] <= q_next;
      dd[s] <= d_prev;
      nn[s] <= n_prev;
      oo[s] <= o_prev;
    end
  end

  logic [W-1:0] q, half;
  logic         clip;

  always_comb begin
    q    = qq[W-1];
    half = W'(1) << (W - 1);
    clip = oo[W-1] | (!nn[W-1] & q[W-1]) | (nn[W-1] & (q > half));
  end

  always_ff @(posedge clk) begin
    sat <= clip;
    if (clip) begin
      coord <= nn[W-1] ? $signed(half) : $signed(half - W'(1));
    end else begin
      coord <= nn[W-1] ? $signed(W'(0) - q) : $signed(q);
    end
  end

endmodule

[rtl/core/three_plane_intersection_core.sv]
// Top level of the three-plane intersection core.
//
// One item holds three planes (normal x, y, z and offset d, signed Q16.16).
// Drive the twelve plane fields and raise start; the item is taken at that
// edge since busy is always low. A new item may be given every cycle.
// Each item gives one result: done is high for exactly one cycle with found,
// point_x, point_y, point_z and saturated valid in that cycle.
// The path runs through seven front stages for operands, products, cofactors,
// determinant, numerators and magnitudes, one stage per quotient bit in the
// divider, one saturation stage and the output register.
// Throughput is one item per cycle; the divider stages make up most of the pipeline.
// A zero determinant gives found = 0 with zero point and saturated = 0.
// Reset clears all valid bits, dropping items in flight; results are never
// held back, since the receiver cannot stall.
module three_plane_intersection_core #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] plane1_nx,
  input  logic signed [VALUE_WIDTH-1:0] plane1_ny,
  input  logic signed [VALUE_WIDTH-1:0] plane1_nz,
  input  logic signed [VALUE_WIDTH-1:0] plane1_d,
  input  logic signed [VALUE_WIDTH-1:0] plane2_nx,
  input  logic signed [VALUE_WIDTH-1:0] plane2_ny,
  input  logic signed [VALUE_WIDTH-1:0] plane2_nz,
  input  logic signed [VALUE_WIDTH-1:0] plane2_d,
  input  logic signed [VALUE_WIDTH-1:0] plane3_nx,
  input  logic signed [VALUE_WIDTH-1:0] plane3_ny,
  input  logic signed [VALUE_WIDTH-1:0] plane3_nz,
  input  logic signed [VALUE_WIDTH-1:0] plane3_d,
  output logic                          done,
  output logic                          found,
  output logic signed [VALUE_WIDTH-1:0] point_x,
  output logic signed [VALUE_WIDTH-1:0] point_y,
  output logic signed [VALUE_WIDTH-1:0] point_z,
  output logic                          saturated
);
  import tpi_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int SW = 3 * W + 4;
  localparam int NW = SW + FRAC_BITS;
  localparam int CL = W + 1;

  tpi_ctl_t              fctl;
  logic [2:0][NW-1:0]    num_mag;
  logic [SW-1:0]         den_mag;
  logic [2:0]            neg, ovf, sat;
  logic signed [W-1:0]   coord [3];
  tpi_ctl_t              cl [CL];

  assign busy = 1'b0;

  tpi_front #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_WIDTH(VALUE_WIDTH),
    .NW         (NW),
    .SW         (SW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (start & ~busy),
    .plane1_nx(plane1_nx),
    .plane1_ny(plane1_ny),
    .plane1_nz(plane1_nz),
    .plane1_d (plane1_d),
    .plane2_nx(plane2_nx),
    .plane2_ny(plane2_ny),
    .plane2_nz(plane2_nz),
    .plane2_d (plane2_d),
    .plane3_nx(plane3_nx),
    .plane3_ny(plane3_ny),
    .plane3_nz(plane3_nz),
    .plane3_d (plane3_d),
    .ctl      (fctl),
    .num_mag  (num_mag),
    .den_mag  (den_mag),
    .neg      (neg),
    .ovf      (ovf)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    tpi_div #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .NW         (NW),
      .DW         (SW)
    ) u_div (
      .clk   (clk),
      .num   (num_mag[k]),
      .den   (den_mag),
      .neg_in(neg[k]),
      .ovf_in(ovf[k]),
      .coord (coord[k]),
      .sat   (sat[k])
    );
  end

  for (genvar i = 0; i < CL; i++) begin : g_ctl
    tpi_ctl_t prev;
    if (i == 0) begin : g_first
      assign prev = fctl;
    end else begin : g_rest
      assign prev = cl[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        cl[i].valid <= 1'b0;
      end else begin
        cl[i].valid <= prev.valid;
      end
      cl[i].found <= prev.found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cl[CL-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    found     <= cl[CL-1].found;
    point_x   <= cl[CL-1].found ? coord[0] : '0;
    point_y   <= cl[CL-1].found ? coord[1] : '0;
    point_z   <= cl[CL-1].found ? coord[2] : '0;
    saturated <= cl[CL-1].found & (|sat);
  end

endmodule

[bench/three_plane_intersection_core_tb.sv]
// Self-checking testbench for the three-plane intersection core.
module three_plane_intersection_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int LATENCY     = VALUE_WIDTH + 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int WIDE        = 192;

  typedef logic signed [VALUE_WIDTH-1:0] word_t;
  typedef logic signed [WIDE-1:0] wide_t;

  typedef struct {
    logic  found;
    word_t px;
    word_t py;
    word_t pz;
    logic  sat;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  word_t p [12];
  logic done, found, saturated;
  word_t point_x, point_y, point_z;

  point_t expected_points [$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  always #5 clk = ~clk;

  three_plane_intersection_core #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .plane1_nx(p[0]), .plane1_ny(p[1]), .plane1_nz(p[2]), .plane1_d(p[3]),
    .plane2_nx(p[4]), .plane2_ny(p[5]), .plane2_nz(p[6]), .plane2_d(p[7]),
    .plane3_nx(p[8]), .plane3_ny(p[9]), .plane3_nz(p[10]), .plane3_d(p[11]),
    .done(done), .found(found), .point_x(point_x), .point_y(point_y),
    .point_z(point_z), .saturated(saturated)
  );

  initial for (int i = 0; i < 12; i++) p[i] = '0;

  function automatic word_t divide_coord(wide_t num, wide_t den, inout logic sat);
    logic neg;
    wide_t n, d, q, lim;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n <<< FRAC_BITS) / d;
    lim = neg ? (wide_t'(1) <<< (VALUE_WIDTH - 1)) : ((wide_t'(1) <<< (VALUE_WIDTH - 1)) - 1);
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    q = neg ? -q : q;
    return word_t'(q);
  endfunction

  function automatic point_t solve_planes(word_t v [12]);
    wide_t m [9];
    wide_t rhs [3];
    wide_t c [9];
    wide_t det, nx, ny, nz;
    point_t r;
    for (int i = 0; i < 3; i++) begin
      m[i*3] = v[i*4]; m[i*3+1] = v[i*4+1]; m[i*3+2] = v[i*4+2];
      rhs[i] = -wide_t'(v[i*4+3]);
    end
    c[0] = m[4]*m[8] - m[5]*m[7];
    c[3] = m[5]*m[6] - m[3]*m[8];
    c[6] = m[3]*m[7] - m[4]*m[6];
    c[1] = m[2]*m[7] - m[1]*m[8];
    c[4] = m[0]*m[8] - m[2]*m[6];
    c[7] = m[1]*m[6] - m[0]*m[7];
    c[2] = m[1]*m[5] - m[2]*m[4];
    c[5] = m[2]*m[3] - m[0]*m[5];
    c[8] = m[0]*m[4] - m[1]*m[3];
    det = m[0]*c[0] + m[1]*c[3] + m[2]*c[6];
    r = '{1'b0, '0, '0, '0, 1'b0};
    if (det == 0) return r;
    nx = c[0]*rhs[0] + c[1]*rhs[1] + c[2]*rhs[2];
    ny = c[3]*rhs[0] + c[4]*rhs[1] + c[5]*rhs[2];
    nz = c[6]*rhs[0] + c[7]*rhs[1] + c[8]*rhs[2];
    r.found = 1'b1;
    r.px = divide_coord(nx, det, r.sat);
    r.py = divide_coord(ny, det, r.sat);
    r.pz = divide_coord(nz, det, r.sat);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst && done) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        point_t e;
        e = expected_points.pop_front();
        if (found !== e.found) report_mismatch("found", found, e.found);
        if (point_x !== e.px) report_mismatch("point_x", point_x, e.px);
        if (point_y !== e.py) report_mismatch("point_y", point_y, e.py);
        if (point_z !== e.pz) report_mismatch("point_z", point_z, e.pz);
        if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
      end
    end
  end

  task automatic send_planes(word_t v [12]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    for (int i = 0; i < 12; i++) p[i] <= v[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_points.push_back(solve_planes(v));
    @(negedge clk);
  endtask

  function automatic word_t rand_word(int kind);
    case (kind)
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      2: return word_t'(($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS);
      default: return word_t'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic test_directed();
    word_t v [12];
    word_t ext [4];
    ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh1};
    for (int i = 0; i < 12; i++) v[i] = '0;
    v[0] = 1 <<< FRAC_BITS; v[5] = 1 <<< FRAC_BITS; v[10] = 1 <<< FRAC_BITS;
    v[3] = -(3 <<< FRAC_BITS); v[7] = 2 <<< FRAC_BITS; v[11] = 5;
    send_planes(v);
    v[8] = v[0]; v[9] = v[1]; v[10] = v[2];
    send_planes(v);
    for (int i = 0; i < 12; i++) v[i] = '0;
    send_planes(v);
    for (int i = 0; i < 12; i++) v[i] = '0;
    v[0] = 1; v[5] = 1; v[10] = 1;
    v[3] = 32'sh80000000; v[7] = 32'sh7fffffff; v[11] = 32'sh7fffffff;
    send_planes(v);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 12; i++) v[i] = ext[(i + k) % 4];
      v[0] = ext[k]; v[5] = ext[(k + 1) % 4]; v[10] = ext[(k + 3) % 4];
      send_planes(v);
    end
    for (int k = 0; k < 12; k++) begin
      for (int i = 0; i < 12; i++) v[i] = (i % 5 == 0) ? ext[k % 2] : ext[(i + k) % 4];
      send_planes(v);
    end
  endtask

  task automatic test_random(int count, int pct);
    word_t v [12];
    int kind;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(3);
      for (int i = 0; i < 12; i++) v[i] = rand_word(kind);
      if ($urandom_range(9) == 0) begin
        for (int i = 0; i < 3; i++) v[8 + i] = v[i];
      end
      send_planes(v);
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500, 0);
    test_random(450, 54);
    test_random(450, 13);
    test_random(450, 0);
    start <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/tpi_pkg.sv
rtl/core/tpi_front.sv
rtl/core/tpi_div.sv
rtl/core/three_plane_intersection_core.sv
bench/three_plane_intersection_core_tb.sv
